// ===== rtl/core/gnss_binary_log_framer_assert.svh =====
// ----------------------------------------------------------------------------
// gnss_binary_log_framer_assert.svh
// Assertion macros shared by the framer RTL.
// ----------------------------------------------------------------------------
`ifndef GNSS_BINARY_LOG_FRAMER_ASSERT_SVH
`define GNSS_BINARY_LOG_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBL_ASSERT_IMP(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBL_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`endif

// ===== rtl/core/gbl_pkg.sv =====
// ----------------------------------------------------------------------------
// gbl_pkg
// Types, constants and payload layout tables of the binary log framer.
// ----------------------------------------------------------------------------
package gbl_pkg;

	localparam int REM_W = 9;
	localparam int WK_W  = 5;
	localparam int BK_W  = 3;

	localparam logic [7:0]  SYNC_BYTE = 8'hAA;
	localparam logic [7:0]  HDR_BYTE1 = 8'h44;
	localparam logic [7:0]  HDR_BYTE2 = 8'h13;
	localparam logic [7:0]  HEAD_TAIL = 8'd12;
	localparam logic [15:0] ID_NAV    = 16'd508;
	localparam logic [15:0] ID_IMU    = 16'd325;
	localparam logic [15:0] ID_COV    = 16'd320;
	localparam logic [15:0] ID_WHEEL  = 16'd622;

	localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		CLS_NAV   = 2'd0,
		CLS_IMU   = 2'd1,
		CLS_COV   = 2'd2,
		CLS_WHEEL = 2'd3
	} msg_class_t;

	// controller -> datapath
	typedef struct packed {
		logic sync_start;
		logic store;
		logic clear_sums;
		logic begin_decode;
		logic rd_issue;
		logic add;
		logic emit;
	} gbl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_sync;
		logic rem_one;
		logic hdr_ok;
		logic id_known;
		logic len_ok;
		logic is_imu;
		logic byte_last;
		logic word_last;
		logic out_free;
	} gbl_stat_t;

	// frame byte offset of word k
	function automatic logic [7:0] word_offset(input msg_class_t cls, input logic [WK_W-1:0] k);
		logic [7:0] off;
		off = 8'd0;
		unique case (cls) inside
			CLS_NAV, CLS_COV: off = 8'd24 + {k, 3'b000};
			CLS_IMU: begin
				unique case (k)
					5'd0:    off = 8'd36;
					5'd1:    off = 8'd32;
					default: off = 8'd28;
				endcase
			end
			default: begin
				unique case (k)
					5'd0:    off = 8'd12;
					5'd1:    off = 8'd14;
					5'd2:    off = 8'd16;
					default: off = 8'd28;
				endcase
			end
		endcase
		return off;
	endfunction

	// bytes in word k
	function automatic logic [3:0] word_nbytes(input msg_class_t cls, input logic [WK_W-1:0] k);
		logic [3:0] n;
		n = 4'd8;
		unique case (cls) inside
			CLS_NAV, CLS_COV: n = 4'd8;
			CLS_IMU:          n = 4'd4;
			default:          n = (k < 5'd2) ? 4'd2 : 4'd4;
		endcase
		return n;
	endfunction

	function automatic logic [WK_W-1:0] word_count(input msg_class_t cls);
		logic [WK_W-1:0] n;
		n = 5'd9;
		unique case (cls)
			CLS_NAV: n = 5'd9;
			CLS_IMU: n = 5'd3;
			CLS_COV: n = 5'd27;
			default: n = 5'd4;
		endcase
		return n;
	endfunction

	function automatic logic [8:0] min_len(input msg_class_t cls);
		logic [8:0] n;
		n = 9'd96;
		unique case (cls)
			CLS_NAV: n = 9'd96;
			CLS_IMU: n = 9'd40;
			CLS_COV: n = 9'd240;
			default: n = 9'd32;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/core/gbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbl_ctrl
// Framing and decode sequencer: hunts sync, walks header and body, then
// steps the datapath through reading, accumulating and emitting words.
// ----------------------------------------------------------------------------
module gbl_ctrl
	import gbl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  logic      kind,
	input  gbl_stat_t stat,
	output gbl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_HEAD,
		ST_BODY,
		ST_CHECK,
		ST_READ,
		ST_DRAIN,
		ST_ADD,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   accepting;
	logic   take_byte;

	assign accepting  = (state_q == ST_HUNT) || (state_q == ST_HEAD) || (state_q == ST_BODY);
	assign byte_stall = !accepting;
	assign take_byte  = byte_valid && accepting && !kind;

	always_comb begin
		cmd = '0;
		cmd.clear_sums = byte_valid && accepting && kind;
		unique case (state_q) inside
			ST_HUNT:          cmd.sync_start = take_byte && stat.is_sync;
			ST_HEAD, ST_BODY: cmd.store = take_byte;
			ST_CHECK:         cmd.begin_decode = stat.id_known && stat.len_ok;
			ST_READ:          cmd.rd_issue = 1'b1;
			ST_ADD:           cmd.add = 1'b1;
			ST_EMIT:          cmd.emit = stat.out_free;
			default:          ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			unique case (state_q)
				ST_HUNT: begin
					if (take_byte && stat.is_sync)
						state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					if (take_byte && stat.rem_one)
						state_q <= stat.hdr_ok ? ST_BODY : ST_HUNT;
				end
				ST_BODY: begin
					if (take_byte && stat.rem_one)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= (stat.id_known && stat.len_ok) ? ST_READ : ST_HUNT;
				end
				ST_READ: begin
					if (stat.byte_last)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= stat.is_imu ? ST_ADD : ST_EMIT;
				end
				ST_ADD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (stat.out_free)
						state_q <= stat.word_last ? ST_HUNT : ST_READ;
				end
				default: state_q <= ST_HUNT;
			endcase
		end
	end

endmodule

// ===== rtl/core/gbl_dpath.sv =====
// ----------------------------------------------------------------------------
// gbl_dpath
// Frame store, header latches, word assembler, saturating sums and the
// output register of the binary log framer.
// ----------------------------------------------------------------------------
module gbl_dpath
	import gbl_pkg::*;
#(
	parameter int FRAME_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  gbl_cmd_t    cmd,
	output gbl_stat_t   stat,
	output logic        word_valid,
	input  logic        word_stall,
	output logic [1:0]  message_class,
	output logic [4:0]  word_index,
	output logic [63:0] word_value,
	output logic        last_word
);

	localparam int AW = $clog2(FRAME_DEPTH);

	logic [7:0]       mem [FRAME_DEPTH];

	logic [REM_W-1:0] rem_q;
	logic [AW-1:0]    wpos_q;
	logic [7:0]       b1_q, b2_q, id_lo_q, id_hi_q;
	msg_class_t       cls_q;
	logic [WK_W-1:0]  wk_q;
	logic [BK_W-1:0]  bk_q;
	logic [7:0]       rd_data_s1;
	logic [BK_W-1:0]  rd_pos_s1;
	logic             rd_val_s1;
	logic [63:0]      acc_q;
	logic [63:0]      sum_q [3];
	logic             out_valid_q;
	logic [1:0]       out_cls_q;
	logic [4:0]       out_idx_q;
	logic [63:0]      out_val_q;
	logic             out_last_q;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [15:0]      msg_id;
	msg_class_t       id_class;
	logic             id_known;
	logic [63:0]      add_s, add_v, add_r, add_new;
	logic             add_ovf;

	assign wr_en   = cmd.sync_start || cmd.store;
	assign wr_addr = cmd.sync_start ? '0 : wpos_q;
	assign rd_addr = AW'(word_offset(cls_q, wk_q)) + AW'(bk_q);

	// frame store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= data_byte;
		if (cmd.rd_issue)
			rd_data_s1 <= mem[rd_addr];
		rd_pos_s1 <= bk_q;
	end

	assign msg_id = {id_hi_q, id_lo_q};

	always_comb begin
		id_known = 1'b1;
		id_class = CLS_NAV;
		if (msg_id == ID_NAV)
			id_class = CLS_NAV;
		else if (msg_id == ID_IMU)
			id_class = CLS_IMU;
		else if (msg_id == ID_COV)
			id_class = CLS_COV;
		else if (msg_id == ID_WHEEL)
			id_class = CLS_WHEEL;
		else
			id_known = 1'b0;
	end

	// saturating accumulate of one raw acceleration
	always_comb begin
		add_s = sum_q[wk_q[1:0]];
		add_v = {{32{acc_q[31]}}, acc_q[31:0]};
		if (wk_q == 5'd1)
			add_v = -add_v;
		add_r   = add_s + add_v;
		add_ovf = (add_s[63] == add_v[63]) && (add_r[63] != add_s[63]);
		add_new = add_ovf ? (add_s[63] ? SUM_MIN : SUM_MAX) : add_r;
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			if (wpos_q == AW'(1))
				b1_q <= data_byte;
			else if (wpos_q == AW'(2))
				b2_q <= data_byte;
			else if (wpos_q == AW'(4))
				id_lo_q <= data_byte;
			else if (wpos_q == AW'(5))
				id_hi_q <= data_byte;
		end
		if (cmd.begin_decode)
			cls_q <= id_class;
		if (rd_val_s1)
			acc_q[{rd_pos_s1, 3'b000} +: 8] <= rd_data_s1;
		else if (cmd.rd_issue && (bk_q == '0))
			acc_q <= '0;
		if (cmd.emit) begin
			out_cls_q  <= cls_q;
			out_idx_q  <= wk_q;
			out_val_q  <= (cls_q == CLS_IMU) ? sum_q[wk_q[1:0]] : acc_q;
			out_last_q <= stat.word_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			wpos_q      <= '0;
			wk_q        <= '0;
			bk_q        <= '0;
			rd_val_s1   <= 1'b0;
			sum_q[0]    <= '0;
			sum_q[1]    <= '0;
			sum_q[2]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_val_s1 <= cmd.rd_issue;
			if (cmd.sync_start) begin
				wpos_q <= AW'(1);
				rem_q  <= REM_W'(3);
			end else if (cmd.store) begin
				wpos_q <= wpos_q + AW'(1);
				if (wpos_q == AW'(3))
					rem_q <= REM_W'(HEAD_TAIL) + REM_W'(data_byte);
				else
					rem_q <= rem_q - REM_W'(1);
			end
			if (cmd.clear_sums) begin
				sum_q[0] <= '0;
				sum_q[1] <= '0;
				sum_q[2] <= '0;
			end else if (cmd.add) begin
				sum_q[wk_q[1:0]] <= add_new;
			end
			if (cmd.begin_decode) begin
				wk_q <= '0;
				bk_q <= '0;
			end else if (cmd.rd_issue) begin
				bk_q <= bk_q + BK_W'(1);
			end else if (cmd.emit) begin
				wk_q <= wk_q + WK_W'(1);
				bk_q <= '0;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!word_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.is_sync   = (data_byte == SYNC_BYTE);
		stat.rem_one   = (rem_q == REM_W'(1));
		stat.hdr_ok    = (b1_q == HDR_BYTE1) && (b2_q == HDR_BYTE2);
		stat.id_known  = id_known;
		stat.len_ok    = (wpos_q >= AW'(min_len(id_class)));
		stat.is_imu    = (cls_q == CLS_IMU);
		stat.byte_last = ((4'(bk_q) + 4'd1) == word_nbytes(cls_q, wk_q));
		stat.word_last = (wk_q == (word_count(cls_q) - WK_W'(1)));
		stat.out_free  = !out_valid_q || !word_stall;
	end

	assign word_valid    = out_valid_q;
	assign message_class = out_cls_q;
	assign word_index    = out_idx_q;
	assign word_value    = out_val_q;
	assign last_word     = out_last_q;

endmodule

// ===== rtl/core/gnss_binary_log_framer.sv =====
// ----------------------------------------------------------------------------
// gnss_binary_log_framer
// Byte-serial framer and decoder for short binary navigation log frames.
// ----------------------------------------------------------------------------
// Each beat on the byte channel carries either a received byte (kind 0) or a
// request to clear the three acceleration sums (kind 1). A byte beat is taken
// without a stall while framing. When the final byte of a frame lands, the byte
// channel stalls while the frame is decoded from the byte-wide frame store:
// the message ID and length are checked, then for every word its bytes
// (2, 4 or 8) are read one by one through the store's single read port,
// the last read is drained, for an IMU word its sum is updated, and the
// word is loaded into the output register once it is free. The frame store
// has no reset and needs no clearing pass; only bytes of the current frame
// are read. The word channel has its own output register, so a waiting
// word does not block byte beats once decoding is done.
// ----------------------------------------------------------------------------
`include "gnss_binary_log_framer_assert.svh"

module gnss_binary_log_framer
	import gbl_pkg::*;
#(
	parameter int FRAME_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        word_valid,
	input  logic        word_stall,
	output logic [1:0]  message_class,
	output logic [4:0]  word_index,
	output logic [63:0] word_value,
	output logic        last_word
);

	gbl_cmd_t  cmd;
	gbl_stat_t stat;

	// sequencer: owns the frame phase and steps the datapath
	gbl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.kind       (kind),
		.stat       (stat),
		.cmd        (cmd)
	);

	// store, assembler, sums and output register
	gbl_dpath #(
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (data_byte),
		.cmd           (cmd),
		.stat          (stat),
		.word_valid    (word_valid),
		.word_stall    (word_stall),
		.message_class (message_class),
		.word_index    (word_index),
		.word_value    (word_value),
		.last_word     (last_word)
	);

	// decode activity only ever happens with the byte channel held off
	`GBL_ASSERT_IMP(a_decode_holds_input, clk, arst_n, cmd.rd_issue || cmd.add || cmd.emit, byte_stall)
	// loading the final word hands the link straight back to sync hunting
	`GBL_ASSERT_NEXT(a_last_word_resumes, clk, arst_n, cmd.emit && stat.word_last, !byte_stall)
	// a navigation frame ends on its ninth word
	`GBL_ASSERT_IMP(a_nav_last_index, clk, arst_n, word_valid && last_word && (message_class == CLS_NAV), word_index == 5'd8)
	// IMU frames carry three sums only
	`GBL_ASSERT_IMP(a_imu_index, clk, arst_n, word_valid && (message_class == CLS_IMU), word_index <= 5'd2)

endmodule

// ===== bench/framer_word_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framer_word_checker
// Watches the byte and word channels of the log framer. It keeps its own
// copy of the framing state, the frame bytes and the acceleration sums, and
// predicts the words of each completed frame. Every word beat is compared,
// field by field, with the oldest word still due.
// ----------------------------------------------------------------------------
module framer_word_checker
	import gbl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	input  logic        word_valid,
	input  logic        word_stall,
	input  logic [1:0]  message_class,
	input  logic [4:0]  word_index,
	input  logic [63:0] word_value,
	input  logic        last_word,
	output int          fail_count,
	output int          words_due_count,
	output int          words_checked,
	output int          frames_decoded,
	output int          clears_seen
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_PAYLOAD
	} frame_phase_t;

	typedef struct {
		msg_class_t  cls;
		logic [4:0]  idx;
		logic [63:0] val;
		logic        last;
	} log_word_t;

	frame_phase_t       phase;
	logic [8:0]         left_cnt;
	logic [8:0]         wr_pos;
	logic [7:0]         frame_mem [0:511];
	logic signed [63:0] accel_acc [0:2];
	log_word_t          words_due [$];

	initial begin
		fail_count      = 0;
		words_due_count = 0;
		words_checked   = 0;
		frames_decoded  = 0;
		clears_seen     = 0;
	end

	// little-endian field of the current frame
	function automatic logic [63:0] frame_field(input int off, input int nbytes);
		logic [63:0] v;
		int i;
		v = '0;
		for (i = nbytes - 1; i >= 0; i--)
			v = {v[55:0], frame_mem[off + i]};
		return v;
	endfunction

	function automatic logic signed [63:0] frame_s32(input int off);
		logic [31:0] w;
		w = 32'(frame_field(off, 4));
		return {{32{w[31]}}, w};
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] s,
			input logic signed [63:0] v);
		logic [64:0] t;
		t = {s[63], s} + {v[63], v};
		if (t[64] != t[63])
			return t[64] ? SUM_MIN : SUM_MAX;
		return t[63:0];
	endfunction

	task automatic queue_word(input msg_class_t c, input int k, input logic [63:0] v,
			input logic last);
		log_word_t w;
		w.cls  = c;
		w.idx  = 5'(k);
		w.val  = v;
		w.last = last;
		words_due.push_back(w);
	endtask

	task automatic decode_frame();
		logic [15:0] msg_id;
		int k;
		msg_id = {frame_mem[5], frame_mem[4]};
		case (msg_id)
			ID_NAV: if (wr_pos >= 9'd96) begin
				for (k = 0; k < 9; k++)
					queue_word(CLS_NAV, k, frame_field(24 + 8 * k, 8), k == 8);
				frames_decoded++;
			end
			ID_COV: if (wr_pos >= 9'd240) begin
				for (k = 0; k < 27; k++)
					queue_word(CLS_COV, k, frame_field(24 + 8 * k, 8), k == 26);
				frames_decoded++;
			end
			ID_WHEEL: if (wr_pos >= 9'd32) begin
				queue_word(CLS_WHEEL, 0, frame_field(12, 2), 1'b0);
				queue_word(CLS_WHEEL, 1, frame_field(14, 2), 1'b0);
				queue_word(CLS_WHEEL, 2, frame_field(16, 4), 1'b0);
				queue_word(CLS_WHEEL, 3, frame_field(28, 4), 1'b1);
				frames_decoded++;
			end
			ID_IMU: if (wr_pos >= 9'd40) begin
				// second axis is negated before it is summed
				accel_acc[0] = sat_add(accel_acc[0], frame_s32(36));
				accel_acc[1] = sat_add(accel_acc[1], -frame_s32(32));
				accel_acc[2] = sat_add(accel_acc[2], frame_s32(28));
				for (k = 0; k < 3; k++)
					queue_word(CLS_IMU, k, accel_acc[k], k == 2);
				frames_decoded++;
			end
			default: ;
		endcase
	endtask

	task automatic predict_beat(input logic k, input logic [7:0] b);
		if (k) begin
			accel_acc[0] = '0;
			accel_acc[1] = '0;
			accel_acc[2] = '0;
			clears_seen++;
		end else begin
			case (phase)
				PH_HEADER: begin
					frame_mem[wr_pos] = b;
					wr_pos++;
					left_cnt--;
					if (left_cnt == 9'd0) begin
						if (frame_mem[1] == HDR_BYTE1 && frame_mem[2] == HDR_BYTE2) begin
							left_cnt = 9'(HEAD_TAIL) + 9'(frame_mem[3]);
							phase    = PH_PAYLOAD;
						end else begin
							phase = PH_HUNT;
						end
					end
				end
				PH_PAYLOAD: begin
					frame_mem[wr_pos] = b;
					wr_pos++;
					left_cnt--;
					if (left_cnt == 9'd0) begin
						phase = PH_HUNT;
						decode_frame();
					end
				end
				default: begin
					phase = PH_HUNT;
					if (b == SYNC_BYTE) begin
						frame_mem[0] = b;
						wr_pos       = 9'd1;
						left_cnt     = 9'd3;
						phase        = PH_HEADER;
					end
				end
			endcase
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		fail_count++;
		$display("MISMATCH at %0t: %s, got %h, want %h", $time, what, got, want);
	endtask

	task automatic check_word();
		log_word_t w;
		if (words_due.size() == 0) begin
			report("word beat with no word due", word_value, 64'd0);
		end else begin
			w = words_due.pop_front();
			if (message_class != w.cls)
				report("message_class", 64'(message_class), 64'(w.cls));
			if (word_index != w.idx)
				report("word_index", 64'(word_index), 64'(w.idx));
			if (word_value != w.val)
				report("word_value", word_value, w.val);
			if (last_word != w.last)
				report("last_word", 64'(last_word), 64'(w.last));
		end
		words_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase        = PH_HUNT;
			left_cnt     = '0;
			wr_pos       = '0;
			accel_acc[0] = '0;
			accel_acc[1] = '0;
			accel_acc[2] = '0;
			words_due.delete();
		end else begin
			if (byte_valid && !byte_stall)
				predict_beat(kind, data_byte);
			if (word_valid && !word_stall)
				check_word();
		end
		words_due_count = words_due.size();
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the binary log framer. Drives byte beats built
// into frames of every message type, broken headers, short and unknown
// frames, idle noise and sum clears, with random gaps on the byte side and
// random stalls on the word side. A checker beside the block predicts and
// compares every word.
// ----------------------------------------------------------------------------
module tb_top;
	import gbl_pkg::*;

	localparam int N_ITEMS     = 460;
	localparam int CYCLE_LIMIT = 200000;
	// a covariance frame holds the input the longest
	localparam int TAIL_CYCLES = 320;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic        kind;
	logic [7:0]  data_byte;
	logic        word_valid;
	logic        word_stall;
	logic [1:0]  message_class;
	logic [4:0]  word_index;
	logic [63:0] word_value;
	logic        last_word;

	int fail_count;
	int words_due_count;
	int words_checked;
	int frames_decoded;
	int clears_seen;

	int items_sent;
	int cycles;
	int stall_left;
	bit quiet_tx;
	bit quiet_rx;

	gnss_binary_log_framer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.word_valid    (word_valid),
		.word_stall    (word_stall),
		.message_class (message_class),
		.word_index    (word_index),
		.word_value    (word_value),
		.last_word     (last_word)
	);

	framer_word_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.kind            (kind),
		.data_byte       (data_byte),
		.word_valid      (word_valid),
		.word_stall      (word_stall),
		.message_class   (message_class),
		.word_index      (word_index),
		.word_value      (word_value),
		.last_word       (last_word),
		.fail_count      (fail_count),
		.words_due_count (words_due_count),
		.words_checked   (words_checked),
		.frames_decoded  (frames_decoded),
		.clears_seen     (clears_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Guard against a hung handshake: give up well past the slowest correct run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still due", cycles, words_due_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Word side: after each word beat, and now and then while idle, draw a
	// fresh random stall. Quiet stretches drop the stall altogether.
	initial begin
		word_stall = 1'b0;
		stall_left = 0;
		quiet_rx   = 1'b0;
		forever begin
			@(posedge clk);
			if ((word_valid && !word_stall) || (stall_left == 0 && $urandom_range(0, 3) == 0)) begin
				if ($urandom_range(0, 15) == 0)
					quiet_rx = !quiet_rx;
				stall_left = quiet_rx ? 0 : $urandom_range(0, 3);
			end
			@(negedge clk);
			word_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// Drive one beat from a falling edge and hold it until it is taken.
	// Count only beats that the block acts on; idle noise is left out.
	task automatic send_beat(input logic k, input logic [7:0] b, input bit counted);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		kind       <= k;
		data_byte  <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		@(negedge clk);
		if (counted)
			items_sent++;
	endtask

	function automatic logic [31:0] pick_accel();
		case ($urandom_range(0, 5))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Build a well-formed frame of 16 + len_byte bytes with random content,
	// sprinkle sync bytes inside it, and now and then slip in a clear beat.
	task automatic send_frame(input logic [15:0] msg_id, input logic [7:0] len_byte);
		logic [7:0]  fr [0:270];
		logic [31:0] a;
		int n;
		int i;
		n = 16 + int'(len_byte);
		for (i = 0; i < n; i++)
			fr[i] = ($urandom_range(0, 15) == 0) ? SYNC_BYTE : 8'($urandom);
		fr[0] = SYNC_BYTE;
		fr[1] = HDR_BYTE1;
		fr[2] = HDR_BYTE2;
		fr[3] = len_byte;
		fr[4] = msg_id[7:0];
		fr[5] = msg_id[15:8];
		// push the raw accelerations towards their extremes
		if (msg_id == ID_IMU && n >= 40) begin
			for (i = 0; i < 3; i++) begin
				a = pick_accel();
				fr[28 + 4 * i] = a[7:0];
				fr[29 + 4 * i] = a[15:8];
				fr[30 + 4 * i] = a[23:16];
				fr[31 + 4 * i] = a[31:24];
			end
		end
		quiet_tx = ($urandom_range(0, 3) == 0);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 47) == 0)
				send_beat(1'b1, 8'($urandom), 1'b1);
			send_beat(1'b0, fr[i], 1'b1);
		end
	endtask

	// Sync followed by a header that fails at byte 1 or byte 2.
	task automatic send_broken_header();
		logic [7:0] b1;
		logic [7:0] b2;
		b1 = ($urandom_range(0, 1) == 0) ? HDR_BYTE1 : 8'($urandom);
		b2 = ($urandom_range(0, 1) == 0) ? HDR_BYTE2 : 8'($urandom);
		if (b1 == HDR_BYTE1 && b2 == HDR_BYTE2)
			b2 = ~b2;
		send_beat(1'b0, SYNC_BYTE, 1'b1);
		send_beat(1'b0, b1, 1'b1);
		send_beat(1'b0, b2, 1'b1);
		send_beat(1'b0, 8'($urandom), 1'b1);
	endtask

	// Known message ID with a length too short for its fields.
	task automatic send_short_frame();
		logic [15:0] msg_id;
		logic [7:0]  need;
		case ($urandom_range(0, 3))
			0: begin msg_id = ID_NAV;   need = 8'd80;  end
			1: begin msg_id = ID_IMU;   need = 8'd24;  end
			2: begin msg_id = ID_COV;   need = 8'd224; end
			default: begin msg_id = ID_WHEEL; need = 8'd16; end
		endcase
		if (msg_id != ID_COV && $urandom_range(0, 1) == 0)
			send_frame(msg_id, need - 8'd1);
		else
			send_frame(msg_id, 8'($urandom_range(0, 7)));
	endtask

	task automatic send_unknown_frame();
		logic [15:0] msg_id;
		msg_id = 16'($urandom);
		while (msg_id == ID_NAV || msg_id == ID_IMU || msg_id == ID_COV || msg_id == ID_WHEEL)
			msg_id = 16'($urandom);
		send_frame(msg_id, 8'($urandom_range(0, 8)));
	endtask

	task automatic send_noise();
		logic [7:0] b;
		int i;
		quiet_tx = 1'b0;
		for (i = 0; i < $urandom_range(1, 4); i++) begin
			b = 8'($urandom);
			if (b == SYNC_BYTE)
				b = 8'h55;
			send_beat(1'b0, b, 1'b0);
		end
	endtask

	initial begin
		int  r;
		bit  cov_sent;
		bit  nav_sent;
		// Hold every input at a known value through reset.
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		kind       = 1'b0;
		data_byte  = 8'h00;
		items_sent = 0;
		cycles     = 0;
		quiet_tx   = 1'b0;
		cov_sent   = 1'b0;
		nav_sent   = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: a clear with all data bits set, a header failing
		// at byte 1, one failing at byte 2 whose last byte is a sync that
		// must not restart framing, and an unknown ID at the shortest length.
		send_beat(1'b1, 8'hFF, 1'b1);
		send_beat(1'b0, SYNC_BYTE, 1'b1);
		send_beat(1'b0, 8'h45, 1'b1);
		send_beat(1'b0, HDR_BYTE2, 1'b1);
		send_beat(1'b0, 8'h05, 1'b1);
		send_beat(1'b0, SYNC_BYTE, 1'b1);
		send_beat(1'b0, HDR_BYTE1, 1'b1);
		send_beat(1'b0, 8'h12, 1'b1);
		send_beat(1'b0, SYNC_BYTE, 1'b1);
		send_frame(16'hFFFF, 8'h00);

		// Random part: mostly well-formed frames with random content,
		// one covariance frame at the largest length and one navigation
		// frame at its shortest valid length, the rest drops and noise.
		while (items_sent < N_ITEMS) begin
			if (!nav_sent && items_sent >= 60) begin
				send_frame(ID_NAV, 8'd80);
				nav_sent = 1'b1;
			end else if (!cov_sent && items_sent >= 150) begin
				send_frame(ID_COV, 8'd255);
				cov_sent = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 35)
					send_frame(ID_IMU, 8'($urandom_range(24, 30)));
				else if (r < 55)
					send_frame(ID_WHEEL, 8'($urandom_range(16, 22)));
				else if (r < 61)
					send_frame(ID_NAV, 8'($urandom_range(80, 82)));
				else if (r < 70)
					send_short_frame();
				else if (r < 76)
					send_unknown_frame();
				else if (r < 85)
					send_broken_header();
				else if (r < 93)
					send_noise();
				else
					send_beat(1'b1, 8'($urandom), 1'b1);
			end
		end
		byte_valid <= 1'b0;

		// Drain: wait for every due word, then a little longer for strays.
		while (words_due_count != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run covered %0d byte and clear beats, %0d decoded frames, %0d sum clears",
			items_sent, frames_decoded, clears_seen);
		$display("and %0d words checked across nav, IMU, covariance and wheel logs",
			words_checked);
		if (fail_count == 0 && words_due_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
